>>> rtl/fsd_pkg.sv
// Shared types, constants and helpers for the FASTA stream deframer.
// Used by fsd_hist, fsd_parse, fsd_outq and fasta_stream_deframer.
// No dependencies.
package fsd_pkg;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int KIND_W = 3;
  localparam int REC_W  = 32;
  localparam int POS_W  = 40;
  localparam int CNT_W  = 32;
  localparam int HLEN_W = 14;
  localparam int MAX_RES = 3;
  localparam int RES_CNT_W = 2;

  // Histogram geometry
  localparam int ALPHABET_SIZE = 256;

  // Behavior constants
  localparam logic [HLEN_W-1:0] HEADER_MAX    = HLEN_W'(8192);
  localparam logic [BYTE_W-1:0] BORDER_SYMBOL = 8'd36;

  // Characters
  localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_SEQ     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BORDER  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ZERO    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HDR     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_HDR_END = 3'd4;

  // Saturation limits
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [REC_W-1:0] REC_MAX = {REC_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [KIND_W-1:0] out_kind;
    logic [REC_W-1:0]  record_number;
    logic [POS_W-1:0]  position;
    logic [CNT_W-1:0]  symbol_count;
    logic              last;
  } out_item_t;

  // All results caused by one input item
  typedef struct packed {
    logic [RES_CNT_W-1:0]      cnt;
    out_item_t [MAX_RES-1:0]   item;
  } res_set_t;

  // Histogram write port
  typedef struct packed {
    logic              en;
    logic [BYTE_W-1:0] addr;
    logic [CNT_W-1:0]  data;
  } hist_wr_t;

  function automatic out_item_t mk_res(logic [BYTE_W-1:0] b, logic [KIND_W-1:0] k,
                                       logic [REC_W-1:0] rec, logic [POS_W-1:0] pos,
                                       logic [CNT_W-1:0] cnt);
    out_item_t r;
    r.out_byte      = b;
    r.out_kind      = k;
    r.record_number = rec;
    r.position      = pos;
    r.symbol_count  = cnt;
    r.last          = 1'b0;
    return r;
  endfunction

endpackage

>>> rtl/fsd_hist.sv
// Symbol histogram: 256 x 32 memory with per-entry valid bits and
// forwarding of the most recent write. Depends on fsd_pkg.
module fsd_hist
  import fsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [BYTE_W-1:0] rd_addr,
  input  logic [BYTE_W-1:0] cur_addr,
  input  hist_wr_t          wr,
  output logic [CNT_W-1:0]  base_cnt
);

  logic [CNT_W-1:0]         mem_r [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] vld_r;
  logic [CNT_W-1:0]         rd_data_r;
  logic                     rd_vld_r;
  logic                     lw_v_r;
  logic [BYTE_W-1:0]        lw_addr_r;
  logic [CNT_W-1:0]         lw_data_r;

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  // Valid bits stand in for the all-zero reset of the counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      lw_v_r <= 1'b0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
      lw_v_r         <= 1'b1;
    end
  end

  // Last write, for a read that raced it
  always_ff @(posedge clk) begin
    if (wr.en) begin
      lw_addr_r <= wr.addr;
      lw_data_r <= wr.data;
    end
  end

  // Forward the last write; unwritten entries read as zero
  always_comb begin
    if (lw_v_r && (lw_addr_r == cur_addr)) begin
      base_cnt = lw_data_r;
    end else if (rd_vld_r) begin
      base_cnt = rd_data_r;
    end else begin
      base_cnt = '0;
    end
  end

  a_wr_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> vld_r[$past(wr.addr)])
    else $error("histogram entry not marked valid after write");

  a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> (lw_v_r && lw_addr_r == $past(wr.addr) && lw_data_r == $past(wr.data)))
    else $error("forwarding register lost the last write");

endmodule

>>> rtl/fsd_parse.sv
// Record parser: header/sequence state, counters and result building
// for the item in the work stage. Depends on fsd_pkg.
module fsd_parse
  import fsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  in_item_t         s1_item,
  input  logic             s1_go,
  input  logic [CNT_W-1:0] hist_base,
  output res_set_t         res,
  output hist_wr_t         hist_wr
);

  logic              ho_r, ho_nxt;
  logic [REC_W-1:0]  rs_r, rs_nxt;
  logic [POS_W-1:0]  sl_r, sl_nxt;
  logic [HLEN_W-1:0] hl_r, hl_nxt;

  logic [BYTE_W-1:0] b;
  logic              is_gt, is_nl, printable, ho_eff, pre, t_v, seq;
  logic [HLEN_W-1:0] hl_eff;
  logic [POS_W-1:0]  sl1, sl2;
  logic [REC_W-1:0]  rs_inc;
  logic [CNT_W-1:0]  cnt_inc;
  out_item_t         t_item;

  // Next-state and result decode
  always_comb begin
    b         = s1_item.in_byte;
    is_gt     = (b == CH_GT);
    is_nl     = (b == CH_NL);
    printable = (b >= PRINT_LO) && (b <= PRINT_HI);
    sl1       = (sl_r == POS_MAX) ? sl_r : sl_r + POS_W'(1);
    sl2       = (sl_r >= POS_MAX - POS_W'(1)) ? POS_MAX : sl_r + POS_W'(2);
    rs_inc    = (rs_r == REC_MAX) ? rs_r : rs_r + REC_W'(1);
    cnt_inc   = (hist_base == CNT_MAX) ? hist_base : hist_base + CNT_W'(1);

    ho_nxt = ho_r;
    rs_nxt = rs_r;
    sl_nxt = sl_r;
    hl_nxt = hl_r;
    res    = '0;
    seq    = 1'b0;
    t_v    = 1'b0;
    t_item = '0;
    ho_eff = 1'b0;
    hl_eff = hl_r;
    pre    = 1'b0;

    if (s1_item.end_of_input) begin
      // End marker: final border only
      res.item[0] = mk_res(BORDER_SYMBOL, KIND_BORDER, rs_r, sl_r, '0);
      res.cnt     = RES_CNT_W'(1);
      sl_nxt      = sl1;
    end else begin
      ho_eff = ho_r | is_gt;
      hl_eff = is_gt ? '0 : hl_r;
      pre    = is_gt && (rs_r != '0);
      rs_nxt = is_gt ? rs_inc : rs_r;
      ho_nxt = ho_eff;
      hl_nxt = hl_eff;

      if (ho_eff) begin
        if (is_nl) begin
          ho_nxt = 1'b0;
          t_v    = 1'b1;
          t_item = mk_res(CH_NUL, KIND_HDR_END, rs_nxt, '0, '0);
        end else if ((hl_eff < HEADER_MAX) && printable) begin
          hl_nxt = hl_eff + HLEN_W'(1);
          t_v    = 1'b1;
          t_item = mk_res(b, KIND_HDR, rs_nxt, '0, '0);
        end
      end else if (!is_nl) begin
        seq    = 1'b1;
        t_v    = 1'b1;
        t_item = mk_res(b, KIND_SEQ, rs_nxt, sl_r, cnt_inc);
        sl_nxt = sl1;
      end

      // A new record after an earlier one is preceded by border and separator
      if (pre) begin
        res.item[0] = mk_res(BORDER_SYMBOL, KIND_BORDER, rs_nxt, sl_r, '0);
        res.item[1] = mk_res(CH_NUL, KIND_ZERO, rs_nxt, sl1, '0);
        res.item[2] = t_item;
        res.cnt     = t_v ? RES_CNT_W'(3) : RES_CNT_W'(2);
        sl_nxt      = sl2;
      end else begin
        res.item[0] = t_item;
        res.cnt     = RES_CNT_W'(t_v);
      end
    end

    hist_wr.en   = s1_go && seq;
    hist_wr.addr = b;
    hist_wr.data = cnt_inc;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ho_r <= 1'b0;
      rs_r <= '0;
      sl_r <= '0;
      hl_r <= '0;
    end else if (s1_go) begin
      ho_r <= ho_nxt;
      rs_r <= rs_nxt;
      sl_r <= sl_nxt;
      hl_r <= hl_nxt;
    end
  end

  a_hl_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    hl_r <= HEADER_MAX)
    else $error("header length ran past its limit");

  a_store_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> sl_r >= $past(sl_r))
    else $error("store position went backward");

endmodule

>>> rtl/fsd_outq.sv
// Result register: holds the up-to-three results of one item and
// hands them out one beat at a time. Depends on fsd_pkg.
module fsd_outq
  import fsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  res_set_t  res,
  output logic      res_free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [RES_CNT_W-1:0]    n_r;
  out_item_t [MAX_RES-1:0] q_r;
  logic                    pop;

  assign out_valid = (n_r != '0);
  assign pop       = out_valid && out_ready;
  assign res_free  = (n_r == '0) || ((n_r == RES_CNT_W'(1)) && out_ready);

  // Head beat; last marks the final result of the item
  always_comb begin
    out_data      = q_r[0];
    out_data.last = (n_r == RES_CNT_W'(1));
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
    end else if (load) begin
      n_r <= res.cnt;
    end else if (pop) begin
      n_r <= n_r - RES_CNT_W'(1);
    end
  end

  // Result payload, shifted toward the head
  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= res.item;
    end else if (pop) begin
      q_r[0] <= q_r[1];
      q_r[1] <= q_r[2];
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> ((n_r == '0) || ((n_r == RES_CNT_W'(1)) && out_ready)))
    else $error("results loaded over pending beats");

  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (n_r == $past(res.cnt)))
    else $error("fill count does not match loaded results");

endmodule

>>> rtl/fasta_stream_deframer.sv
// FASTA stream deframer: one byte per beat in, sequence/header/border beats out.
// Each accepted input beat is registered in the work stage, and its results are registered in the result register.
// Throughput: one input byte per cycle, bounded by the result port at one beat
// per cycle (a record opener after the first record yields three beats).
// Histogram read at accept, updated as the item leaves the work stage, with forwarding.
// Reset (rst_n low, synchronous) clears all counters, header state and histogram.
module fasta_stream_deframer
  import fsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic             s1_v_r;
  in_item_t         s1_r;
  logic             s1_go;
  logic             in_acc;
  logic             res_free;
  logic             load;
  logic [CNT_W-1:0] hist_base;
  res_set_t         res;
  hist_wr_t         hist_wr;

  // Work-stage handshake; items with no result never wait
  assign s1_go    = s1_v_r && ((res.cnt == '0) || res_free);
  assign in_ready = !s1_v_r || s1_go;
  assign in_acc   = in_valid && in_ready;
  assign load     = s1_go && (res.cnt != '0);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_data;
    end
  end

  fsd_hist u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr  (in_data.in_byte),
    .cur_addr (s1_r.in_byte),
    .wr       (hist_wr),
    .base_cnt (hist_base)
  );

  fsd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_item   (s1_r),
    .s1_go     (s1_go),
    .hist_base (hist_base),
    .res       (res),
    .hist_wr   (hist_wr)
  );

  fsd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res       (res),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_go) |=> (s1_v_r && $stable(s1_r)))
    else $error("work stage item lost while stalled");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_ready)
    else $error("input stalled with empty work stage");

endmodule

>>> bench/fasta_stream_deframer_tb.sv
// Self-checking bench for fasta_stream_deframer: directed and random FASTA byte streams.
// Results are predicted beat by beat and compared against the result channel.
// Depends on fsd_pkg and the fasta_stream_deframer RTL.
module fasta_stream_deframer_tb;
  import fsd_pkg::*;

  // Predicts the beats a byte stream turns into and checks what comes out
  class deframer_scoreboard;
    logic              in_header;
    logic [REC_W-1:0]  records_opened;
    logic [POS_W-1:0]  store_fill;
    logic [HLEN_W-1:0] header_fill;
    logic [CNT_W-1:0]  byte_hist [ALPHABET_SIZE];
    out_item_t         expected_beats [$];
    int                mismatches;

    function new();
      in_header      = 1'b0;
      records_opened = '0;
      store_fill     = '0;
      header_fill    = '0;
      foreach (byte_hist[i]) byte_hist[i] = '0;
      mismatches     = 0;
    endfunction

    // Next store offset; sticks at the top once full
    function logic [POS_W-1:0] next_slot();
      logic [POS_W-1:0] slot;
      slot = store_fill;
      if (store_fill != POS_MAX) store_fill++;
      return slot;
    endfunction

    function out_item_t make_beat(logic [BYTE_W-1:0] b, logic [KIND_W-1:0] kind,
                                  logic [POS_W-1:0] pos, logic [CNT_W-1:0] cnt);
      out_item_t beat;
      beat.out_byte      = b;
      beat.out_kind      = kind;
      beat.record_number = records_opened;
      beat.position      = pos;
      beat.symbol_count  = cnt;
      beat.last          = 1'b0;
      return beat;
    endfunction

    // Accepted input beat: queue the results it causes, return how many
    function int note_beat(in_item_t it);
      out_item_t         beats [$];
      logic [BYTE_W-1:0] b;
      logic              reopen;
      b = it.in_byte;
      if (it.end_of_input) begin
        beats.push_back(make_beat(BORDER_SYMBOL, KIND_BORDER, next_slot(), '0));
      end else begin
        if (b == CH_GT) begin
          // '>' opens a record even inside an open header
          in_header = 1'b1;
          reopen = (records_opened != '0);
          header_fill = '0;
          if (records_opened != REC_MAX) records_opened++;
          if (reopen) begin
            beats.push_back(make_beat(BORDER_SYMBOL, KIND_BORDER, next_slot(), '0));
            beats.push_back(make_beat(CH_NUL, KIND_ZERO, next_slot(), '0));
          end
        end
        if (in_header) begin
          if (b == CH_NL) begin
            in_header = 1'b0;
            beats.push_back(make_beat(CH_NUL, KIND_HDR_END, '0, '0));
          end else if (header_fill < HEADER_MAX && b >= PRINT_LO && b <= PRINT_HI) begin
            header_fill++;
            beats.push_back(make_beat(b, KIND_HDR, '0, '0));
          end
        end else if (b != CH_NL) begin
          if (byte_hist[b] != CNT_MAX) byte_hist[b]++;
          beats.push_back(make_beat(b, KIND_SEQ, next_slot(), byte_hist[b]));
        end
      end
      if (beats.size() > 0) beats[beats.size()-1].last = 1'b1;
      foreach (beats[i]) expected_beats.push_back(beats[i]);
      return beats.size();
    endfunction

    // Result beat: compare with the oldest prediction
    function void check_result(out_item_t got);
      out_item_t want;
      logic      same;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing predicted: byte %h kind %0d",
                   $realtime, got.out_byte, got.out_kind);
        return;
      end
      want = expected_beats.pop_front();
      same = (got.out_byte === want.out_byte) && (got.out_kind === want.out_kind) &&
             (got.record_number === want.record_number) &&
             (got.position === want.position) &&
             (got.symbol_count === want.symbol_count) && (got.last === want.last);
      if (!same) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch, expected byte %h kind %0d rec %0d pos %0d cnt %0d last %b",
                   $realtime, want.out_byte, want.out_kind, want.record_number,
                   want.position, want.symbol_count, want.last);
          $display("%0t:           actual byte %h kind %0d rec %0d pos %0d cnt %0d last %b",
                   $realtime, got.out_byte, got.out_kind, got.record_number,
                   got.position, got.symbol_count, got.last);
        end
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  deframer_scoreboard sb = new();

  bit          sender_idles = 1'b1;
  bit          receiver_stalls = 1'b1;
  int          burst_left = 0;
  int          items_sent = 0;
  logic [15:0] stall_pat = '0;
  int          pat_left = 0;

  fasta_stream_deframer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Receiver: when stalls are on, ready follows the bits of a random 16-bit pattern, reloaded once used up
  always @(posedge clk) begin
    if (!receiver_stalls) begin
      out_ready <= 1'b1;
    end else begin
      if (pat_left == 0) begin
        stall_pat = 16'($urandom);
        pat_left = 16;
      end
      out_ready <= stall_pat[0];
      stall_pat = stall_pat >> 1;
      pat_left--;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Send one beat; the sender runs in bursts with random gaps between them
  task automatic send_beat(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (sender_idles) begin
        gap = $urandom_range(0, 5);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    void'(sb.note_beat(it));
    items_sent++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    in_item_t it;
    it.in_byte      = b;
    it.end_of_input = 1'b0;
    send_beat(it);
  endtask

  task automatic send_end(input logic [BYTE_W-1:0] junk);
    in_item_t it;
    it.in_byte      = junk;
    it.end_of_input = 1'b1;
    send_beat(it);
  endtask

  // Printable header character other than '>'
  function automatic logic [BYTE_W-1:0] header_char();
    logic [BYTE_W-1:0] c;
    c = 8'($urandom_range(PRINT_LO, PRINT_HI));
    return (c == CH_GT) ? 8'h78 : c;
  endfunction

  // Mostly nucleotides, now and then any byte
  function automatic logic [BYTE_W-1:0] residue();
    logic [BYTE_W-1:0] bases [10] = '{8'h41, 8'h43, 8'h47, 8'h54, 8'h4E,
                                      8'h61, 8'h63, 8'h67, 8'h74, 8'h6E};
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    return bases[$urandom_range(0, 9)];
  endfunction

  // Record with random content: header line, then sequence lines (random bytes may break the format)
  task automatic send_record();
    int hdr_len;
    int lines;
    int line_len;
    send_byte(CH_GT);
    hdr_len = $urandom_range(0, 12);
    for (int i = 0; i < hdr_len; i++) begin
      if ($urandom_range(0, 9) == 0) send_byte(8'($urandom));
      else send_byte(header_char());
    end
    send_byte(CH_NL);
    lines = $urandom_range(1, 3);
    for (int l = 0; l < lines; l++) begin
      line_len = $urandom_range(0, 10);
      for (int i = 0; i < line_len; i++) send_byte(residue());
      send_byte(CH_NL);
    end
  endtask

  // Timeout
  initial begin
    #24000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: end before any record, bytes before a header, header edge cases
    send_end(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_NL);          // newline outside a header is dropped
    send_byte(CH_GT);          // first record: no border
    send_byte(PRINT_LO);
    send_byte(PRINT_HI);
    send_byte(8'h1F);          // non-printable header bytes are dropped
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(CH_GT);          // '>' inside a header opens another record
    send_byte(CH_NL);
    send_byte(8'h41);
    send_byte(8'h41);
    send_end(CH_GT);
    send_byte(8'h43);          // input after the end marker
    send_byte(CH_GT);
    send_byte(CH_NL);          // empty header
    send_byte(CH_NL);
    send_byte(8'h3D);
    send_end(8'h00);

    // Random: mostly records, some noise and bare end markers
    while (items_sent < 215) begin
      sender_idles    = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: begin
          for (int i = 0; i < 4; i++) begin
            if ($urandom_range(0, 15) == 0) send_end(8'($urandom));
            else send_byte(8'($urandom));
          end
        end
        1: send_end(8'($urandom));
        default: send_record();
      endcase
    end
    send_end(8'($urandom));
    in_valid <= 1'b0;

    // Drain, then allow for stray beats
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/fsd_pkg.sv
rtl/fsd_hist.sv
rtl/fsd_parse.sv
rtl/fsd_outq.sv
rtl/fasta_stream_deframer.sv
bench/fasta_stream_deframer_tb.sv
